[sv/tdd_pkg.sv]
// ----------------------------------------------------------------------------
// tdd_pkg
// Types and constants of the telemetry datagram deframer.
// ----------------------------------------------------------------------------
package tdd_pkg;

    typedef enum logic [1:0] {
        KIND_PAYLOAD  = 2'd0,
        KIND_COMPLETE = 2'd1,
        KIND_BAD_TYPE = 2'd2
    } kind_t;

    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 8;

    localparam logic [CFG_ADDR_W-1:0] REG_PREAMBLE_BYTE = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_PREAMBLE_LEN  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_CONTROL_BYTE  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_TYPE_COUNT    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_PAYLOAD_LEN_0 = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_PAYLOAD_LEN_1 = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_PAYLOAD_LEN_2 = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_PAYLOAD_LEN_3 = 3'd7;

    localparam logic [7:0] RST_PREAMBLE_BYTE = 8'd85;
    localparam logic [3:0] RST_PREAMBLE_LEN  = 4'd4;
    localparam logic [7:0] RST_CONTROL_BYTE  = 8'd255;
    localparam logic [2:0] RST_TYPE_COUNT    = 3'd4;
    localparam logic [7:0] RST_PAYLOAD_LEN   = 8'd1;
    localparam logic [2:0] MAX_TYPES         = 3'd4;

    localparam int unsigned M_TDATA_W = 56;

endpackage

[sv/telemetry_datagram_deframer.sv]
// A result is registered and appears on m_ in the cycle after the byte that causes it is accepted.
// Throughput: one byte per cycle; s_tready drops only while a result waits on m_.
// The per-byte state machine and the output register set that figure.
// Reset (aresetn low, synchronous): hunting for preamble, counters and header
// registers cleared, configuration back to its defaults, output empty.
// ----------------------------------------------------------------------------
// telemetry_datagram_deframer
// Hunts for a preamble, parses the header, forwards payload bytes and skips
// the checksum of each telemetry datagram; reports completion and bad types.
// ----------------------------------------------------------------------------
module telemetry_datagram_deframer #(
    parameter int unsigned SEQ_BYTES      = 4,
    parameter int unsigned CHECKSUM_BYTES = 2
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_we,
    input  logic [tdd_pkg::CFG_ADDR_W-1:0]       cfg_addr,
    input  logic [tdd_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [7:0]                           s_tdata,   // [7:0] data_byte
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // [7:0] payload_data, [39:8] sequence_number, [47:40] payload_kind,
    // [55:48] byte_index
    output logic [tdd_pkg::M_TDATA_W-1:0]        m_tdata,
    output logic [1:0]                           m_tuser,   // [1:0] kind
    output logic                                 m_tlast    // last
);

    typedef enum logic [2:0] {
        PH_HUNT     = 3'd0,
        PH_HEADER   = 3'd1,
        PH_CONTROL  = 3'd2,
        PH_PAYLOAD  = 3'd3,
        PH_CHECKSUM = 3'd4
    } phase_t;

    logic [7:0]  preamble_byte_reg;
    logic [3:0]  preamble_len_reg;
    logic [7:0]  control_byte_reg;
    logic [2:0]  type_count_reg;
    logic [7:0]  payload_len_reg [4];

    phase_t      phase_reg, phase_next;
    logic [7:0]  count_reg, count_next;
    logic [31:0] seq_reg, seq_next;
    logic [7:0]  type_reg, type_next;

    logic        res_valid;
    logic [1:0]  res_kind;
    logic [7:0]  res_data;
    logic [7:0]  res_index;
    logic        res_last;

    logic        m_valid_reg;
    logic [1:0]  m_kind_reg;
    logic [7:0]  m_data_reg;
    logic [31:0] m_seq_reg;
    logic [7:0]  m_type_reg;
    logic [7:0]  m_index_reg;
    logic        m_last_reg;

    logic        s_acc;
    logic [3:0]  need;
    logic [2:0]  type_lim;
    logic [7:0]  pay_len;
    logic        fin;

    assign s_tready = !m_valid_reg || m_tready;
    assign s_acc    = s_tvalid && s_tready;

    assign need     = (preamble_len_reg == 4'd0) ? 4'd1 : preamble_len_reg;
    assign type_lim = (type_count_reg > tdd_pkg::MAX_TYPES) ? tdd_pkg::MAX_TYPES
                                                            : type_count_reg;
    assign pay_len  = (payload_len_reg[type_reg[1:0]] == 8'd0) ? 8'd1
                                                               : payload_len_reg[type_reg[1:0]];
    assign fin      = ({1'b0, count_reg} + 9'd1) >= {1'b0, pay_len};

    always_comb begin
        phase_next = phase_reg;
        count_next = count_reg;
        seq_next   = seq_reg;
        type_next  = type_reg;
        res_valid  = 1'b0;
        res_kind   = tdd_pkg::KIND_PAYLOAD;
        res_data   = 8'd0;
        res_index  = 8'd0;
        res_last   = 1'b0;
        case (phase_reg)
            PH_HEADER: begin
                if (count_reg < 8'(SEQ_BYTES)) begin
                    seq_next   = {seq_reg[23:0], s_tdata};
                    count_next = count_reg + 8'd1;
                end else begin
                    type_next = s_tdata;
                    if (s_tdata < {5'd0, type_lim}) begin
                        phase_next = PH_CONTROL;
                        count_next = 8'd0;
                    end else begin
                        res_valid  = 1'b1;
                        res_kind   = tdd_pkg::KIND_BAD_TYPE;
                        phase_next = PH_HUNT;
                        count_next = 8'd0;
                    end
                end
            end
            PH_CONTROL: begin
                phase_next = (s_tdata == control_byte_reg) ? PH_PAYLOAD : PH_HUNT;
                count_next = 8'd0;
            end
            PH_PAYLOAD: begin
                res_valid = 1'b1;
                res_data  = s_tdata;
                res_index = count_reg;
                res_last  = fin;
                if (fin) begin
                    phase_next = PH_CHECKSUM;
                    count_next = 8'd0;
                end else begin
                    count_next = count_reg + 8'd1;
                end
            end
            PH_CHECKSUM: begin
                count_next = count_reg + 8'd1;
                if (count_next >= 8'(CHECKSUM_BYTES)) begin
                    res_valid  = 1'b1;
                    res_kind   = tdd_pkg::KIND_COMPLETE;
                    phase_next = PH_HUNT;
                    count_next = 8'd0;
                end
            end
            default: begin
                phase_next = PH_HUNT;
                count_next = (s_tdata == preamble_byte_reg) ? count_reg + 8'd1 : 8'd0;
                if (count_next >= {4'd0, need}) begin
                    phase_next = PH_HEADER;
                    count_next = 8'd0;
                    seq_next   = 32'd0;
                    type_next  = 8'd0;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            preamble_byte_reg  <= tdd_pkg::RST_PREAMBLE_BYTE;
            preamble_len_reg   <= tdd_pkg::RST_PREAMBLE_LEN;
            control_byte_reg   <= tdd_pkg::RST_CONTROL_BYTE;
            type_count_reg     <= tdd_pkg::RST_TYPE_COUNT;
            payload_len_reg[0] <= tdd_pkg::RST_PAYLOAD_LEN;
            payload_len_reg[1] <= tdd_pkg::RST_PAYLOAD_LEN;
            payload_len_reg[2] <= tdd_pkg::RST_PAYLOAD_LEN;
            payload_len_reg[3] <= tdd_pkg::RST_PAYLOAD_LEN;
        end else if (cfg_we) begin
            case (cfg_addr)
                tdd_pkg::REG_PREAMBLE_BYTE: preamble_byte_reg  <= cfg_wdata;
                tdd_pkg::REG_PREAMBLE_LEN:  preamble_len_reg   <= cfg_wdata[3:0];
                tdd_pkg::REG_CONTROL_BYTE:  control_byte_reg   <= cfg_wdata;
                tdd_pkg::REG_TYPE_COUNT:    type_count_reg     <= cfg_wdata[2:0];
                tdd_pkg::REG_PAYLOAD_LEN_0: payload_len_reg[0] <= cfg_wdata;
                tdd_pkg::REG_PAYLOAD_LEN_1: payload_len_reg[1] <= cfg_wdata;
                tdd_pkg::REG_PAYLOAD_LEN_2: payload_len_reg[2] <= cfg_wdata;
                tdd_pkg::REG_PAYLOAD_LEN_3: payload_len_reg[3] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_HUNT;
            count_reg   <= 8'd0;
            seq_reg     <= 32'd0;
            type_reg    <= 8'd0;
            m_valid_reg <= 1'b0;
            m_kind_reg  <= tdd_pkg::KIND_PAYLOAD;
            m_data_reg  <= 8'd0;
            m_seq_reg   <= 32'd0;
            m_type_reg  <= 8'd0;
            m_index_reg <= 8'd0;
            m_last_reg  <= 1'b0;
        end else begin
            if (s_acc) begin
                phase_reg   <= phase_next;
                count_reg   <= count_next;
                seq_reg     <= seq_next;
                type_reg    <= type_next;
                m_valid_reg <= res_valid;
                if (res_valid) begin
                    m_kind_reg  <= res_kind;
                    m_data_reg  <= res_data;
                    m_seq_reg   <= seq_next;
                    m_type_reg  <= type_next;
                    m_index_reg <= res_index;
                    m_last_reg  <= res_last;
                end
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {m_index_reg, m_type_reg, m_seq_reg, m_data_reg};

    a_kind_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == tdd_pkg::KIND_PAYLOAD || m_tuser == tdd_pkg::KIND_COMPLETE
                      || m_tuser == tdd_pkg::KIND_BAD_TYPE))
        else $error("illegal result kind");

    a_nonpayload_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != tdd_pkg::KIND_PAYLOAD)
            |-> (m_tdata[7:0] == 8'd0 && m_tdata[55:48] == 8'd0 && !m_tlast))
        else $error("non-payload result carries payload fields");

    a_payload_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && phase_reg == PH_PAYLOAD)
            |=> (m_tvalid && m_tuser == tdd_pkg::KIND_PAYLOAD))
        else $error("payload byte gave no result");

    a_hunt_exit: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && phase_reg == PH_HUNT) |=> (phase_reg == PH_HUNT || phase_reg == PH_HEADER))
        else $error("hunt left to wrong phase");

    a_checksum_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_CHECKSUM) |-> (count_reg < 8'(CHECKSUM_BYTES)))
        else $error("checksum count overran");

endmodule

[sim/tdd_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tdd_checker
// Watches the config port and both streams of the telemetry datagram
// deframer, keeps its own model of the parser and of the registers, and
// checks every result item against the oldest expected record.
// ----------------------------------------------------------------------------
module tdd_checker #(
    parameter int unsigned SEQ_BYTES      = 4,
    parameter int unsigned CHECKSUM_BYTES = 2
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [tdd_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [tdd_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [7:0]                       s_tdata,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [tdd_pkg::M_TDATA_W-1:0]    m_tdata,
    input  logic [1:0]                       m_tuser,
    input  logic                             m_tlast,
    output int unsigned                      mismatch_count,
    output int unsigned                      awaited_count
);

    typedef enum logic [2:0] {
        PARSE_HUNT     = 3'd0,
        PARSE_HEADER   = 3'd1,
        PARSE_CONTROL  = 3'd2,
        PARSE_PAYLOAD  = 3'd3,
        PARSE_CHECKSUM = 3'd4
    } parse_state_t;

    typedef struct packed {
        tdd_pkg::kind_t kind;
        logic [7:0]     data;
        logic [31:0]    seq_num;
        logic [7:0]     ptype;
        logic [7:0]     index;
        logic           last;
    } deframed_t;

    logic [7:0]   sync_byte;
    logic [3:0]   sync_len;
    logic [7:0]   ctrl_byte;
    logic [2:0]   valid_types;
    logic [7:0]   len_by_type [4];

    parse_state_t parse_state;
    logic [7:0]   count;
    logic [31:0]  seq_acc;
    logic [7:0]   type_acc;

    deframed_t    awaited_records [$];

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("[%0t] deframer mismatch: %s", $time, msg);
    endtask

    function automatic string describe(input deframed_t r);
        return $sformatf("kind=%0d data=%02h seq=%08h type=%02h idx=%0d last=%0b",
                         r.kind, r.data, r.seq_num, r.ptype, r.index, r.last);
    endfunction

    task automatic post_record(input tdd_pkg::kind_t k, input logic [7:0] d,
                               input logic [7:0] idx, input logic fin);
        deframed_t rec;
        rec.kind    = k;
        rec.data    = d;
        rec.seq_num = seq_acc;
        rec.ptype   = type_acc;
        rec.index   = idx;
        rec.last    = fin;
        awaited_records = {awaited_records, rec};
    endtask

    task automatic deframe_byte(input logic [7:0] b);
        logic [2:0] lim;
        logic [7:0] len;
        logic [3:0] need;
        case (parse_state)
            PARSE_HEADER: begin
                if (count < SEQ_BYTES) begin
                    seq_acc = {seq_acc[23:0], b};
                    count++;
                end else begin
                    type_acc = b;
                    lim = (valid_types < tdd_pkg::MAX_TYPES) ? valid_types
                                                             : tdd_pkg::MAX_TYPES;
                    if (b < lim) begin
                        parse_state = PARSE_CONTROL;
                        count = '0;
                    end else begin
                        post_record(tdd_pkg::KIND_BAD_TYPE, 8'd0, 8'd0, 1'b0);
                        parse_state = PARSE_HUNT;
                        count = '0;
                    end
                end
            end
            PARSE_CONTROL: begin
                parse_state = (b == ctrl_byte) ? PARSE_PAYLOAD : PARSE_HUNT;
                count = '0;
            end
            PARSE_PAYLOAD: begin
                len = (len_by_type[type_acc[1:0]] == 8'd0) ? 8'd1 : len_by_type[type_acc[1:0]];
                if (int'(count) + 1 >= int'(len)) begin
                    post_record(tdd_pkg::KIND_PAYLOAD, b, count, 1'b1);
                    parse_state = PARSE_CHECKSUM;
                    count = '0;
                end else begin
                    post_record(tdd_pkg::KIND_PAYLOAD, b, count, 1'b0);
                    count++;
                end
            end
            PARSE_CHECKSUM: begin
                count++;
                if (count >= CHECKSUM_BYTES) begin
                    post_record(tdd_pkg::KIND_COMPLETE, 8'd0, 8'd0, 1'b0);
                    parse_state = PARSE_HUNT;
                    count = '0;
                end
            end
            default: begin
                // unused state codes hunt as well
                need = (sync_len == 4'd0) ? 4'd1 : sync_len;
                parse_state = PARSE_HUNT;
                count = (b == sync_byte) ? count + 8'd1 : 8'd0;
                if (count >= need) begin
                    parse_state = PARSE_HEADER;
                    count = '0;
                    seq_acc = '0;
                    type_acc = '0;
                end
            end
        endcase
    endtask

    always @(posedge aclk) begin
        deframed_t got;
        deframed_t want;
        string     diffs;
        if (!aresetn) begin
            sync_byte      = tdd_pkg::RST_PREAMBLE_BYTE;
            sync_len       = tdd_pkg::RST_PREAMBLE_LEN;
            ctrl_byte      = tdd_pkg::RST_CONTROL_BYTE;
            valid_types    = tdd_pkg::RST_TYPE_COUNT;
            for (int i = 0; i < 4; i++)
                len_by_type[i] = tdd_pkg::RST_PAYLOAD_LEN;
            parse_state    = PARSE_HUNT;
            count          = '0;
            seq_acc        = '0;
            type_acc       = '0;
            mismatch_count = 0;
            awaited_records.delete();
        end else begin
            // results are registered in the deframer, so compare before predicting
            if (m_tvalid && m_tready) begin
                got.kind    = tdd_pkg::kind_t'(m_tuser);
                got.data    = m_tdata[7:0];
                got.seq_num = m_tdata[39:8];
                got.ptype   = m_tdata[47:40];
                got.index   = m_tdata[55:48];
                got.last    = m_tlast;
                if (awaited_records.size() == 0) begin
                    report_mismatch({"unexpected item ", describe(got)});
                end else begin
                    want  = awaited_records.pop_front();
                    diffs = "";
                    if (got.kind !== want.kind)       diffs = {diffs, " kind"};
                    if (got.data !== want.data)       diffs = {diffs, " payload_data"};
                    if (got.seq_num !== want.seq_num) diffs = {diffs, " sequence_number"};
                    if (got.ptype !== want.ptype)     diffs = {diffs, " payload_kind"};
                    if (got.index !== want.index)     diffs = {diffs, " byte_index"};
                    if (got.last !== want.last)       diffs = {diffs, " last"};
                    if (diffs != "")
                        report_mismatch($sformatf("%s: got %s, exp %s", diffs,
                                                  describe(got), describe(want)));
                end
            end
            if (s_tvalid && s_tready)
                deframe_byte(s_tdata);
            if (cfg_we) begin
                case (cfg_addr)
                    tdd_pkg::REG_PREAMBLE_BYTE: sync_byte      = cfg_wdata;
                    tdd_pkg::REG_PREAMBLE_LEN:  sync_len       = cfg_wdata[3:0];
                    tdd_pkg::REG_CONTROL_BYTE:  ctrl_byte      = cfg_wdata;
                    tdd_pkg::REG_TYPE_COUNT:    valid_types    = cfg_wdata[2:0];
                    tdd_pkg::REG_PAYLOAD_LEN_0: len_by_type[0] = cfg_wdata;
                    tdd_pkg::REG_PAYLOAD_LEN_1: len_by_type[1] = cfg_wdata;
                    tdd_pkg::REG_PAYLOAD_LEN_2: len_by_type[2] = cfg_wdata;
                    tdd_pkg::REG_PAYLOAD_LEN_3: len_by_type[3] = cfg_wdata;
                    default: ;
                endcase
            end
        end
        awaited_count <= awaited_records.size();
    end

endmodule

[sim/tb_telemetry_datagram_deframer.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_telemetry_datagram_deframer
// Feeds the deframer two short directed byte runs and then phases of random
// datagrams (good, bad type, bad control, noise, cut preambles) under several
// register settings, with random gaps and back-pressure. tdd_checker does the
// prediction and comparison; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_telemetry_datagram_deframer;

    localparam int unsigned SEQ_BYTES   = 4;
    localparam int unsigned CHECK_BYTES = 2;

    typedef enum int {
        DG_GOOD,
        DG_BAD_TYPE,
        DG_BAD_CONTROL,
        DG_NOISE,
        DG_SHORT_SYNC
    } dg_shape_t;

    logic                           aclk;
    logic                           aresetn;
    logic                           cfg_we;
    logic [tdd_pkg::CFG_ADDR_W-1:0] cfg_addr;
    logic [tdd_pkg::CFG_DATA_W-1:0] cfg_wdata;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [7:0]                     s_tdata;    // [7:0] data_byte
    logic                           m_tvalid;
    logic                           m_tready = 1'b1;
    // [7:0] payload_data, [39:8] sequence_number, [47:40] payload_kind,
    // [55:48] byte_index
    logic [tdd_pkg::M_TDATA_W-1:0]  m_tdata;
    logic [1:0]                     m_tuser;    // [1:0] kind
    logic                           m_tlast;
    int unsigned                    mismatch_count;
    int unsigned                    awaited_count;

    // stimulus-side copy of the registers, used to build datagrams
    logic [7:0]             cur_pb;
    logic [3:0]             cur_plen;
    logic [7:0]             cur_ctrl;
    logic [2:0]             cur_tc;
    logic [7:0]             cur_len [4];

    bit                     tx_idle;
    bit                     rx_idle;
    int                     stall_left = 0;
    int                     fed_items;

    telemetry_datagram_deframer #(
        .SEQ_BYTES      (SEQ_BYTES),
        .CHECKSUM_BYTES (CHECK_BYTES)
    ) uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    tdd_checker #(
        .SEQ_BYTES      (SEQ_BYTES),
        .CHECKSUM_BYTES (CHECK_BYTES)
    ) u_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .m_tlast        (m_tlast),
        .mismatch_count (mismatch_count),
        .awaited_count  (awaited_count)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("tb_telemetry_datagram_deframer failed");
        $finish;
    end

    // receiver back-pressure in random bursts
    always @(posedge aclk) begin
        if (stall_left != 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (rx_idle && $urandom_range(0, 5) == 0) begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(0, 2);
        end else begin
            m_tready <= 1'b1;
        end
    end

    function automatic logic [7:0] rnd8();
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_byte(input logic [7:0] b);
        if (tx_idle && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        fed_items++;
    endtask

    // sends the n lowest bytes of the vector, most significant first
    task automatic send_packed(input logic [255:0] bytes, input int n);
        for (int i = 0; i < n; i++)
            send_byte(bytes[8*(n-1-i) +: 8]);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (awaited_count != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic apply_settings(input logic [7:0] pb, input logic [3:0] plen,
                                  input logic [7:0] ctrl, input logic [2:0] tc,
                                  input logic [7:0] l0, input logic [7:0] l1,
                                  input logic [7:0] l2, input logic [7:0] l3);
        logic [tdd_pkg::CFG_ADDR_W-1:0] addrs [8];
        logic [7:0]                     vals  [8];
        addrs = '{tdd_pkg::REG_PREAMBLE_BYTE, tdd_pkg::REG_PREAMBLE_LEN,
                  tdd_pkg::REG_CONTROL_BYTE, tdd_pkg::REG_TYPE_COUNT,
                  tdd_pkg::REG_PAYLOAD_LEN_0, tdd_pkg::REG_PAYLOAD_LEN_1,
                  tdd_pkg::REG_PAYLOAD_LEN_2, tdd_pkg::REG_PAYLOAD_LEN_3};
        vals  = '{pb, {4'd0, plen}, ctrl, {5'd0, tc}, l0, l1, l2, l3};
        for (int i = 0; i < 8; i++) begin
            cfg_we    <= 1'b1;
            cfg_addr  <= addrs[i];
            cfg_wdata <= vals[i];
            @(posedge aclk);
        end
        cfg_we   <= 1'b0;
        cur_pb   = pb;
        cur_plen = plen;
        cur_ctrl = ctrl;
        cur_tc   = tc;
        cur_len  = '{l0, l1, l2, l3};
    endtask

    task automatic send_datagram(input dg_shape_t shape, input int forced_type);
        dg_shape_t sh;
        int        need;
        int        lim;
        int        t;
        int        n;
        logic [7:0] b;
        sh   = shape;
        need = (cur_plen == 4'd0) ? 1 : int'(cur_plen);
        lim  = (cur_tc < tdd_pkg::MAX_TYPES) ? int'(cur_tc) : int'(tdd_pkg::MAX_TYPES);
        if (lim == 0 && (sh == DG_GOOD || sh == DG_BAD_CONTROL))
            sh = DG_BAD_TYPE;
        if (sh == DG_SHORT_SYNC && need == 1)
            sh = DG_NOISE;
        case (sh)
            DG_NOISE: begin
                n = $urandom_range(1, 6);
                repeat (n) begin
                    b = rnd8();
                    if (b == cur_pb)
                        b = ~b;
                    send_byte(b);
                end
                // hunting discards these bytes
                fed_items -= n;
            end
            DG_SHORT_SYNC: begin
                repeat (need - 1) send_byte(cur_pb);
                send_byte(~cur_pb);
            end
            default: begin
                repeat (need) send_byte(cur_pb);
                repeat (SEQ_BYTES) send_byte(rnd8());
                if (sh == DG_BAD_TYPE)
                    t = ($urandom_range(0, 3) == 0) ? lim : $urandom_range(lim, 255);
                else
                    t = (forced_type >= 0) ? forced_type : $urandom_range(0, lim - 1);
                send_byte(8'(t));
                if (sh == DG_BAD_CONTROL) begin
                    send_byte(cur_ctrl ^ 8'($urandom_range(1, 255)));
                end else if (sh == DG_GOOD) begin
                    send_byte(cur_ctrl);
                    n = (cur_len[t] == 8'd0) ? 1 : int'(cur_len[t]);
                    repeat (n) send_byte(rnd8());
                    repeat (CHECK_BYTES) send_byte(rnd8());
                end
            end
        endcase
    endtask

    initial begin
        int        start;
        int        r;
        dg_shape_t shape;

        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_addr  = tdd_pkg::REG_PREAMBLE_BYTE;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        tx_idle   = 1'b0;
        rx_idle   = 1'b0;
        fed_items = 0;
        cur_pb    = tdd_pkg::RST_PREAMBLE_BYTE;
        cur_plen  = tdd_pkg::RST_PREAMBLE_LEN;
        cur_ctrl  = tdd_pkg::RST_CONTROL_BYTE;
        cur_tc    = tdd_pkg::RST_TYPE_COUNT;
        cur_len   = '{tdd_pkg::RST_PAYLOAD_LEN, tdd_pkg::RST_PAYLOAD_LEN,
                      tdd_pkg::RST_PAYLOAD_LEN, tdd_pkg::RST_PAYLOAD_LEN};

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        tx_idle = 1'b1;
        rx_idle <= 1'b1;

        // reset settings: all-ones sequence number, highest valid type
        send_packed(256'({8'h55, 8'h55, 8'h55, 8'h55, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                          8'h03, 8'hFF, 8'hFF, 8'h00, 8'h00}), 13);
        drain();

        // zero preamble length, type count above four, zero payload lengths
        apply_settings(8'h00, 4'd0, 8'h00, 3'd7, 8'd0, 8'd0, 8'd0, 8'd0);
        send_packed(256'({8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h04}), 6);
        send_packed(256'({8'h00, 8'h80, 8'h01, 8'h02, 8'h7F, 8'h00, 8'h00, 8'hA5,
                          8'h5A, 8'hC3}), 10);
        drain();

        for (int ph = 0; ph < 9; ph++) begin
            case (ph)
                0: apply_settings(8'hFF, 4'd8, 8'h00, 3'd4, 8'd3, 8'd1, 8'd8, 8'd255);
                1: apply_settings(rnd8(), 4'd1, rnd8(), 3'd1, 8'd1, 8'd2, 8'd3, 8'd4);
                2: apply_settings(rnd8(), 4'd15, rnd8(), 3'd2, 8'd0, 8'd5, 8'd0, 8'd2);
                3: apply_settings(rnd8(), 4'd0, rnd8(), 3'd0, 8'd2, 8'd2, 8'd2, 8'd2);
                4: apply_settings(rnd8(), 4'd2, 8'hFF, 3'd7, 8'd2, 8'd4, 8'd6, 8'd8);
                5: apply_settings(8'h00, 4'd3, rnd8(), 3'd3,
                                  8'($urandom_range(1, 6)), 8'($urandom_range(1, 6)),
                                  8'($urandom_range(1, 6)), 8'($urandom_range(1, 6)));
                6: apply_settings(rnd8(), 4'($urandom_range(1, 8)), rnd8(), 3'd4,
                                  8'($urandom_range(1, 8)), 8'($urandom_range(1, 8)),
                                  8'($urandom_range(1, 8)), 8'($urandom_range(1, 8)));
                7: apply_settings(rnd8(), 4'($urandom_range(1, 8)), rnd8(),
                                  3'($urandom_range(1, 7)),
                                  8'($urandom_range(1, 8)), 8'($urandom_range(1, 8)),
                                  8'($urandom_range(1, 8)), 8'($urandom_range(1, 8)));
                default: apply_settings(tdd_pkg::RST_PREAMBLE_BYTE, tdd_pkg::RST_PREAMBLE_LEN,
                                        tdd_pkg::RST_CONTROL_BYTE, tdd_pkg::RST_TYPE_COUNT,
                                        tdd_pkg::RST_PAYLOAD_LEN, tdd_pkg::RST_PAYLOAD_LEN,
                                        tdd_pkg::RST_PAYLOAD_LEN, tdd_pkg::RST_PAYLOAD_LEN);
            endcase
            start = fed_items;
            // one full-length payload on type 3
            if (ph == 0)
                send_datagram(DG_GOOD, 3);
            while (fed_items - start < 170) begin
                r       = $urandom_range(0, 99);
                tx_idle = (ph != 8) && ($urandom_range(0, 3) != 0);
                rx_idle <= (ph != 8) && ($urandom_range(0, 3) != 0);
                if (r < 78)
                    shape = DG_GOOD;
                else if (r < 86)
                    shape = DG_BAD_TYPE;
                else if (r < 92)
                    shape = DG_BAD_CONTROL;
                else if (r < 96)
                    shape = DG_NOISE;
                else
                    shape = DG_SHORT_SYNC;
                send_datagram(shape, -1);
            end
            drain();
        end

        if (mismatch_count == 0) begin
            $display("tb_telemetry_datagram_deframer passed");
        end else begin
            $display("tb_telemetry_datagram_deframer failed");
        end
        $finish;
    end

endmodule

[filelist.f]
sv/tdd_pkg.sv
sv/telemetry_datagram_deframer.sv
sim/tdd_checker.sv
sim/tb_telemetry_datagram_deframer.sv
